/* rtl/cxm_pkg.sv */
// Shared types, codes and constants for the channel to extended memory adapter.
package cxm_pkg;

  localparam int unsigned ChanW  = 12;
  localparam int unsigned AddrW  = 24;
  localparam int unsigned MemW   = 60;
  localparam int unsigned StatW  = 6;
  localparam int unsigned SettleW = 8;

  // stream payload widths (packed, padded to bytes)
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 104;
  localparam int unsigned UserW    = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // configuration defaults
  localparam logic               DefHighBitsSpecial = 1'b1;
  localparam logic [SettleW-1:0] DefReadSettleTicks = 8'd20;
  localparam logic [SettleW-1:0] SettleMax          = 8'd255;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_HIGH_BITS   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SETTLE      = 2'd1;

  // function codes (octal)
  localparam logic [ChanW-1:0] FUNC_MASK = 12'o7077;
  localparam logic [ChanW-1:0] FC_READ   = 12'o5001;
  localparam logic [ChanW-1:0] FC_WRITE  = 12'o5002;
  localparam logic [ChanW-1:0] FC_STATUS = 12'o5004;
  localparam logic [ChanW-1:0] FC_CLEAR  = 12'o5010;
  localparam logic [ChanW-1:0] FC_MREAD  = 12'o5021;
  localparam logic [ChanW-1:0] FC_MWRITE = 12'o5022;
  localparam logic [ChanW-1:0] FC_FLAG   = 12'o5040;
  localparam logic [ChanW-1:0] FC_RDONE  = 12'o5041;
  localparam logic [ChanW-1:0] FC_SELECT = 12'o5404;

  // status register values
  localparam logic [StatW-1:0] ST_ABORT  = 6'd1;
  localparam logic [StatW-1:0] ST_ACCEPT = 6'd2;

  // input modes
  localparam logic [2:0] MODE_FUNC  = 3'd0;
  localparam logic [2:0] MODE_WORD  = 3'd1;
  localparam logic [2:0] MODE_POLL  = 3'd2;
  localparam logic [2:0] MODE_TICK  = 3'd3;
  localparam logic [2:0] MODE_DISC  = 3'd4;
  localparam logic [2:0] MODE_REPLY = 3'd5;

  // result kinds
  localparam logic [2:0] KIND_FUNC  = 3'd0;
  localparam logic [2:0] KIND_CHAN  = 3'd1;
  localparam logic [2:0] KIND_RDREQ = 3'd2;
  localparam logic [2:0] KIND_WRREQ = 3'd3;
  localparam logic [2:0] KIND_FLAG  = 3'd4;
  localparam logic [2:0] KIND_WRDONE = 3'd5;

  // function reply status
  localparam logic [1:0] FS_ACCEPTED  = 2'd0;
  localparam logic [1:0] FS_PROCESSED = 2'd1;
  localparam logic [1:0] FS_DECLINED  = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_READ   = 3'd1,
    OP_WRITE  = 3'd2,
    OP_STATUS = 3'd3,
    OP_MREAD  = 3'd4,
    OP_MWRITE = 3'd5,
    OP_FLAG   = 3'd6,
    OP_RDONE  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    AW_NONE  = 2'd0,
    AW_READ  = 2'd1,
    AW_WRITE = 2'd2,
    AW_FLAG  = 2'd3
  } aw_t;

  typedef struct packed {
    op_t                op;
    logic [AddrW-1:0]   addr;
    logic [1:0]         acnt;
    logic [2:0]         bidx;
    logic               fetch;
    logic [MemW-1:0]    word;
    logic [StatW-1:0]   status;
    logic [SettleW-1:0] settle;
    aw_t                aw;
    logic               wab;
  } cxm_state_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [1:0]       func_status;
    logic [ChanW-1:0] out_word;
    logic             disconnect_after;
    logic             deactivate;
    logic [AddrW-1:0] mem_address;
    logic [MemW-1:0]  mem_data;
  } cxm_result_t;

  typedef struct packed {
    logic               high_bits_special;
    logic [SettleW-1:0] read_settle_ticks;
  } cxm_cfg_t;

endpackage

/* rtl/cxm_step.sv */
// Next-state and result logic for one input word of the adapter.
module cxm_step (
  input  cxm_pkg::cxm_state_t   st,
  input  cxm_pkg::cxm_cfg_t     cfg,
  input  logic [2:0]            mode,
  input  logic [11:0]           chan_word,
  input  logic [59:0]           reply_word,
  input  logic                  reply_ok,
  output cxm_pkg::cxm_state_t   nx,
  output logic                  res_valid,
  output cxm_pkg::cxm_result_t  res
);
  import cxm_pkg::*;

  logic [ChanW-1:0] fm;
  logic             is_rd;
  logic             rd_one;
  logic             op_hit;
  op_t              op_sel;
  logic [AddrW-1:0] addr_sh;
  logic [MemW-1:0]  word_sh;
  logic [MemW-1:0]  word_pad;
  logic [2:0]       bidx_inc;
  logic             flag_acc;

  assign fm       = chan_word & FUNC_MASK;
  assign is_rd    = (st.op == OP_READ) || (st.op == OP_MREAD) ||
                    (st.op == OP_FLAG) || (st.op == OP_RDONE);
  assign rd_one   = cfg.high_bits_special ? st.addr[22] : (st.op == OP_RDONE);
  assign addr_sh  = {st.addr[AddrW-ChanW-1:0], chan_word};
  assign word_sh  = {st.word[MemW-ChanW-1:0], chan_word};
  assign bidx_inc = st.bidx + 3'd1;
  assign flag_acc = cfg.high_bits_special ? addr_sh[23] : (st.op == OP_FLAG);

  always_comb begin
    case (st.bidx)
      3'd1:    word_pad = {st.word[11:0], 48'd0};
      3'd2:    word_pad = {st.word[23:0], 36'd0};
      3'd3:    word_pad = {st.word[35:0], 24'd0};
      3'd4:    word_pad = {st.word[47:0], 12'd0};
      default: word_pad = st.word;
    endcase
  end

  always_comb begin
    op_hit = 1'b0;
    op_sel = OP_NONE;
    case (fm)
      FC_READ:   begin op_hit = 1'b1; op_sel = OP_READ;   end
      FC_WRITE:  begin op_hit = 1'b1; op_sel = OP_WRITE;  end
      FC_STATUS: begin op_hit = 1'b1; op_sel = OP_STATUS; end
      FC_MREAD:  begin op_hit = 1'b1; op_sel = OP_MREAD;  end
      FC_MWRITE: begin op_hit = 1'b1; op_sel = OP_MWRITE; end
      FC_FLAG:   begin op_hit = 1'b1; op_sel = OP_FLAG;   end
      FC_RDONE:  begin op_hit = 1'b1; op_sel = OP_RDONE;  end
      default:   ;
    endcase
  end

  always_comb begin
    nx        = st;
    res_valid = 1'b0;
    res       = '0;
    case (mode)
      MODE_FUNC: begin
        nx.wab    = 1'b0;
        nx.aw     = AW_NONE;
        res_valid = 1'b1;
        res.kind  = KIND_FUNC;
        if (op_hit) begin
          if (op_sel == OP_WRITE || op_sel == OP_MWRITE) begin
            nx.word = '0;
          end
          nx.addr  = '0;
          nx.acnt  = 2'd0;
          nx.bidx  = 3'd0;
          nx.fetch = 1'b0;
          nx.op    = op_sel;
          res.func_status = FS_ACCEPTED;
        end else if (fm == FC_CLEAR) begin
          nx.op     = OP_NONE;
          nx.status = ST_ACCEPT;
          res.func_status = FS_PROCESSED;
        end else if (fm == FC_SELECT) begin
          res.func_status = FS_PROCESSED;
        end else begin
          res.func_status = FS_DECLINED;
        end
      end
      MODE_TICK: begin
        if (st.settle != SettleMax) begin
          nx.settle = st.settle + 8'd1;
        end
      end
      MODE_REPLY: begin
        nx.aw = AW_NONE;
        case (st.aw)
          AW_FLAG: begin
            nx.status = reply_ok ? ST_ACCEPT : ST_ABORT;
          end
          AW_READ: begin
            // first word of the fetched block goes straight out
            nx.word   = {reply_word[MemW-ChanW-1:0], 12'd0};
            nx.status = reply_ok ? ST_ACCEPT : ST_ABORT;
            nx.fetch  = 1'b0;
            nx.bidx   = 3'd1;
            res_valid = 1'b1;
            res.kind  = KIND_CHAN;
            res.out_word = reply_word[MemW-1:MemW-ChanW];
            res.disconnect_after = ~reply_ok;
          end
          AW_WRITE: begin
            res_valid = 1'b1;
            res.kind  = KIND_WRDONE;
            res.mem_address = st.addr;
            if (reply_ok) begin
              nx.word = '0;
              nx.bidx = 3'd0;
              nx.addr = st.addr + 24'd1;
            end else begin
              nx.status = ST_ABORT;
              nx.wab    = 1'b1;
              res.deactivate = 1'b1;
            end
          end
          default: ;
        endcase
      end
      MODE_WORD: begin
        if (st.aw == AW_NONE && st.op != OP_NONE && st.op != OP_STATUS) begin
          if (st.acnt != 2'd2) begin
            nx.addr = addr_sh;
            nx.acnt = st.acnt + 2'd1;
            if (st.acnt == 2'd1 && is_rd) begin
              nx.settle = '0;
              nx.bidx   = 3'd0;
              if (flag_acc) begin
                nx.word   = '0;
                nx.fetch  = 1'b0;
                nx.aw     = AW_FLAG;
                res_valid = 1'b1;
                res.kind  = KIND_FLAG;
                res.mem_address = addr_sh;
              end else begin
                nx.fetch = 1'b1;
              end
            end
          end else if (!is_rd && !st.wab) begin
            nx.status = ST_ACCEPT;
            if (st.bidx >= 3'd4) begin
              if (st.op != OP_MWRITE) begin
                // index sticks at five: each further word is a full block
                nx.word   = word_sh;
                nx.bidx   = 3'd5;
                nx.aw     = AW_WRITE;
                res_valid = 1'b1;
                res.kind  = KIND_WRREQ;
                res.mem_address = st.addr;
                res.mem_data    = word_sh;
              end else begin
                nx.word = '0;
                nx.bidx = 3'd0;
                nx.addr = st.addr + 24'd1;
              end
            end else begin
              nx.word = word_sh;
              nx.bidx = bidx_inc;
            end
          end
        end
      end
      MODE_POLL: begin
        if (st.aw == AW_NONE) begin
          if (st.op == OP_STATUS) begin
            nx.op     = OP_NONE;
            res_valid = 1'b1;
            res.kind  = KIND_CHAN;
            res.out_word = {{(ChanW-StatW){1'b0}}, st.status};
          end else if (is_rd && st.acnt == 2'd2 && st.settle > cfg.read_settle_ticks) begin
            res_valid = 1'b1;
            if (st.fetch) begin
              nx.aw    = AW_READ;
              res.kind = KIND_RDREQ;
              res.mem_address = cfg.high_bits_special ? {3'd0, st.addr[20:0]} : st.addr;
            end else begin
              res.kind     = KIND_CHAN;
              res.out_word = st.word[MemW-1:MemW-ChanW];
              nx.word      = {st.word[MemW-ChanW-1:0], 12'd0};
              nx.bidx      = bidx_inc;
              if (bidx_inc >= 3'd5) begin
                res.disconnect_after = rd_one;
                nx.bidx  = 3'd0;
                nx.fetch = 1'b1;
                nx.addr  = st.addr + 24'd1;
              end
            end
          end
        end
      end
      MODE_DISC: begin
        if (st.aw == AW_NONE && st.op == OP_WRITE && !st.wab &&
            st.bidx != 3'd0 && st.bidx < 3'd5) begin
          nx.word   = word_pad;
          nx.aw     = AW_WRITE;
          res_valid = 1'b1;
          res.kind  = KIND_WRREQ;
          res.mem_address = st.addr;
          res.mem_data    = word_pad;
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/channel_to_extended_memory_adapter.sv */
// Top level of the 12-bit channel to 60-bit extended memory adapter.
//
//  channel | dir | payload                                   | handshake
//  --------+-----+-------------------------------------------+-----------------
//  in_     | in  | tuser mode, tdata chan/reply word, ok     | tvalid/tready
//  out_    | out | tuser kind, tdata status/word/addr/data   | tvalid/tready
//  cfg_    | in  | index, data                               | valid/ready
//
// One word every cycle unless stalled: an accepted word is held in the input register,
// then the step logic updates the adapter state and loads the result register.
// Any word, with or without a result, waits in the input register while the
// result register is full and not being taken; in_tready drops only then.
// Reset (rst_n low, synchronous) sets state and config to defaults, clears both valid flags.
// Configuration writes are always taken (cfg_ready high).
module channel_to_extended_memory_adapter (
  input  logic                                clk,
  input  logic                                rst_n,
  // input words
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [cxm_pkg::UserW-1:0]           in_tuser,  // [2:0] mode
  input  logic [cxm_pkg::InDataW-1:0]         in_tdata,  // [11:0] chan_word, [71:12] reply_word,
                                                         // [72] reply_ok, rest zero
  // result words
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [cxm_pkg::UserW-1:0]           out_tuser, // [2:0] kind
  output logic [cxm_pkg::OutDataW-1:0]        out_tdata, // [1:0] func_status, [13:2] out_word,
                                                         // [14] disconnect_after, [15] deactivate,
                                                         // [39:16] mem_address, [99:40] mem_data
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cxm_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [cxm_pkg::CfgDataW-1:0]        cfg_data
);
  import cxm_pkg::*;

  // input register
  logic               in_v_r;
  logic [2:0]         mode_r;
  logic [ChanW-1:0]   chan_r;
  logic [MemW-1:0]    reply_r;
  logic               ok_r;

  // adapter state and configuration
  cxm_state_t  st_r, st_nxt;
  cxm_cfg_t    cfg_r;

  // result register
  logic         out_v_r;
  cxm_result_t  res_r;
  cxm_result_t  res_nxt;
  logic         res_valid;

  logic proc_go;
  logic in_acc;

  // step fires when the result slot is free or being emptied this cycle
  assign proc_go   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || proc_go;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  cxm_step u_step (
    .st         (st_r),
    .cfg        (cfg_r),
    .mode       (mode_r),
    .chan_word  (chan_r),
    .reply_word (reply_r),
    .reply_ok   (ok_r),
    .nx         (st_nxt),
    .res_valid  (res_valid),
    .res        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r  <= in_tuser;
      chan_r  <= in_tdata[ChanW-1:0];
      reply_r <= in_tdata[ChanW+MemW-1:ChanW];
      ok_r    <= in_tdata[ChanW+MemW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.op     <= OP_NONE;
      st_r.addr   <= '0;
      st_r.acnt   <= 2'd0;
      st_r.bidx   <= 3'd0;
      st_r.fetch  <= 1'b0;
      st_r.word   <= '0;
      st_r.status <= ST_ACCEPT;
      st_r.settle <= '0;
      st_r.aw     <= AW_NONE;
      st_r.wab    <= 1'b0;
    end else if (proc_go) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.high_bits_special <= DefHighBitsSpecial;
      cfg_r.read_settle_ticks <= DefReadSettleTicks;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_HIGH_BITS: cfg_r.high_bits_special <= cfg_data[0];
        CFG_SETTLE:    cfg_r.read_settle_ticks <= cfg_data;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proc_go) begin
      out_v_r <= res_valid;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && res_valid) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = res_r.kind;
  assign out_tdata  = {4'd0, res_r.mem_data, res_r.mem_address, res_r.deactivate,
                       res_r.disconnect_after, res_r.out_word, res_r.func_status};

endmodule

/* rtl/cxm_checker.sv */
// Port-level checks for the adapter, bound to the top level.
module cxm_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [2:0]   out_tuser,
  input logic [103:0] out_tdata
);
  import cxm_pkg::*;

  // a stalled result word holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // only defined kinds leave the block
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= KIND_WRDONE)
    else $error("undefined result kind");

  // write data field is zero except on a write request
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_WRREQ |-> out_tdata[99:40] == 60'd0)
    else $error("mem_data set on non-write result");

  // a fresh result follows an accepted input word through the two registers
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without an accepted input word");

endmodule

bind channel_to_extended_memory_adapter cxm_checker u_cxm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata)
);

/* tb/testbench.sv */
// Self-checking testbench for the channel to extended memory adapter.
`timescale 1ns / 100ps

module testbench;
  import cxm_pkg::*;

  // unused input modes: the adapter must ignore them
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;
  // a function code that matches nothing, even after masking
  localparam logic [ChanW-1:0] FC_UNKNOWN = 12'o1234;
  // function code bits dropped by the mask
  localparam logic [ChanW-1:0] FC_DONT_CARE = ~FUNC_MASK;
  localparam int QUIET_LIMIT = 1000;
  localparam int MAX_GAP = 40;
  localparam int SETTLE_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [UserW-1:0]    in_tuser = '0;    // [2:0] mode
  logic [InDataW-1:0]  in_tdata = '0;    // [11:0] chan_word, [71:12] reply_word, [72] reply_ok
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [UserW-1:0]    out_tuser;        // [2:0] kind
  logic [OutDataW-1:0] out_tdata;        // [1:0] func_status, [13:2] out_word,
                                         // [14] disconnect_after, [15] deactivate,
                                         // [39:16] mem_address, [99:40] mem_data
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  channel_to_extended_memory_adapter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // traffic shaping, changed per phase
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int words_sent = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  cxm_result_t pending_results[$];

  // shadow copy of the adapter state and its two registers
  op_t                st_op;
  logic [AddrW-1:0]   st_addr;
  logic [1:0]         st_acnt;
  logic [2:0]         st_bidx;
  logic               st_fetch;
  logic [MemW-1:0]    st_word;
  logic [StatW-1:0]   st_status;
  logic [SettleW-1:0] st_settle;
  aw_t                st_aw;
  logic               st_wab;
  logic               set_hbs;
  logic [SettleW-1:0] set_ticks;

  // ---------------------------------------------------------------------------
  // Shadow model of the adapter
  // ---------------------------------------------------------------------------
  function automatic bit reading_op();
    return st_op == OP_READ || st_op == OP_MREAD || st_op == OP_FLAG || st_op == OP_RDONE;
  endfunction

  function automatic bit one_word_read();
    return set_hbs ? st_addr[22] : (st_op == OP_RDONE);
  endfunction

  // hand the top 12 bits of the memory word to the channel
  function automatic cxm_result_t next_chan_word(input logic disc);
    cxm_result_t r;
    r = '0;
    r.kind = KIND_CHAN;
    r.out_word = st_word[MemW-1 -: ChanW];
    st_word = st_word << ChanW;
    st_bidx = st_bidx + 3'd1;
    if (st_bidx >= 3'd5) begin
      if (one_word_read()) disc = 1'b1;
      st_bidx = '0;
      st_fetch = 1'b1;
      st_addr = st_addr + 1'b1;
    end
    r.disconnect_after = disc;
    return r;
  endfunction

  function automatic cxm_result_t write_req();
    cxm_result_t r;
    r = '0;
    r.kind = KIND_WRREQ;
    r.mem_address = st_addr;
    r.mem_data = st_word;
    st_aw = AW_WRITE;
    return r;
  endfunction

  // one accepted input word in, at most one result out
  function automatic bit adapter_step(input logic [2:0] mode, input logic [ChanW-1:0] cw,
                                      input logic [MemW-1:0] rw, input logic ok,
                                      output cxm_result_t r);
    logic [ChanW-1:0] fc;
    op_t nxt;
    bit known;
    aw_t was;
    r = '0;
    nxt = OP_NONE;
    case (mode)
      MODE_FUNC: begin
        st_wab = 1'b0;
        st_aw = AW_NONE;
        r.kind = KIND_FUNC;
        fc = cw & FUNC_MASK;
        known = 1'b1;
        case (fc)
          FC_READ:   nxt = OP_READ;
          FC_WRITE:  nxt = OP_WRITE;
          FC_STATUS: nxt = OP_STATUS;
          FC_MREAD:  nxt = OP_MREAD;
          FC_MWRITE: nxt = OP_MWRITE;
          FC_FLAG:   nxt = OP_FLAG;
          FC_RDONE:  nxt = OP_RDONE;
          default:   known = 1'b0;
        endcase
        if (fc == FC_CLEAR) begin
          st_op = OP_NONE;
          st_status = ST_ACCEPT;
          r.func_status = FS_PROCESSED;
        end else if (fc == FC_SELECT) begin
          r.func_status = FS_PROCESSED;
        end else if (!known) begin
          r.func_status = FS_DECLINED;
        end else begin
          if (nxt == OP_WRITE || nxt == OP_MWRITE) st_word = '0;
          st_addr = '0;
          st_acnt = '0;
          st_bidx = '0;
          st_fetch = 1'b0;
          st_op = nxt;
          r.func_status = FS_ACCEPTED;
        end
        return 1'b1;
      end
      MODE_TICK: begin
        if (st_settle != SettleMax) st_settle = st_settle + 1'b1;
        return 1'b0;
      end
      MODE_REPLY: begin
        was = st_aw;
        st_aw = AW_NONE;
        case (was)
          AW_FLAG: begin
            st_status = ok ? ST_ACCEPT : ST_ABORT;
            return 1'b0;
          end
          AW_READ: begin
            st_word = rw;
            st_status = ok ? ST_ACCEPT : ST_ABORT;
            st_fetch = 1'b0;
            st_bidx = '0;
            r = next_chan_word(!ok);
            return 1'b1;
          end
          AW_WRITE: begin
            r.kind = KIND_WRDONE;
            r.mem_address = st_addr;
            if (ok) begin
              st_word = '0;
              st_bidx = '0;
              st_addr = st_addr + 1'b1;
            end else begin
              st_status = ST_ABORT;
              st_wab = 1'b1;
              r.deactivate = 1'b1;
            end
            return 1'b1;
          end
          default: return 1'b0;
        endcase
      end
      default: ;
    endcase

    // everything below is held off while a memory reply is outstanding
    if (st_aw != AW_NONE) return 1'b0;

    case (mode)
      MODE_WORD: begin
        if (st_op == OP_NONE || st_op == OP_STATUS) return 1'b0;
        if (st_acnt < 2'd2) begin
          st_addr = {st_addr[ChanW-1:0], cw};
          st_acnt = st_acnt + 2'd1;
          if (st_acnt == 2'd2 && reading_op()) begin
            st_settle = '0;
            if (set_hbs ? st_addr[AddrW-1] : (st_op == OP_FLAG)) begin
              st_bidx = '0;
              st_word = '0;
              st_fetch = 1'b0;
              r.kind = KIND_FLAG;
              r.mem_address = st_addr;
              st_aw = AW_FLAG;
              return 1'b1;
            end
            st_fetch = 1'b1;
            st_bidx = '0;
          end
          return 1'b0;
        end
        if (reading_op() || st_wab) return 1'b0;
        st_status = ST_ACCEPT;
        st_word = {st_word[MemW-ChanW-1:0], cw};
        // index sticks at five: every count past it behaves the same
        if (st_bidx < 3'd5) st_bidx = st_bidx + 3'd1;
        if (st_bidx >= 3'd5) begin
          if (st_op != OP_MWRITE) begin
            r = write_req();
            return 1'b1;
          end
          // maintenance write: the word is dropped, only the address moves
          st_word = '0;
          st_bidx = '0;
          st_addr = st_addr + 1'b1;
        end
        return 1'b0;
      end
      MODE_POLL: begin
        if (st_op == OP_STATUS) begin
          r.kind = KIND_CHAN;
          r.out_word = {{(ChanW-StatW){1'b0}}, st_status};
          st_op = OP_NONE;
          return 1'b1;
        end
        if (!reading_op() || st_acnt < 2'd2 || st_settle <= set_ticks) return 1'b0;
        if (st_fetch) begin
          r.kind = KIND_RDREQ;
          r.mem_address = set_hbs ? {3'b000, st_addr[20:0]} : st_addr;
          st_aw = AW_READ;
          return 1'b1;
        end
        r = next_chan_word(1'b0);
        return 1'b1;
      end
      MODE_DISC: begin
        if (st_op != OP_WRITE || st_wab || st_bidx == 3'd0 || st_bidx >= 3'd5) return 1'b0;
        // pad the missing low words with zeros
        st_word = st_word << (ChanW * (5 - st_bidx));
        r = write_req();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  function automatic logic [MemW-1:0] rand_mem_word();
    return MemW'({$urandom, $urandom});
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  // with in_tvalid still high, so back-to-back words need no extra edge
  task automatic send_word(input logic [2:0] mode, input logic [ChanW-1:0] cw,
                           input logic [MemW-1:0] rw, input logic ok);
    cxm_result_t r;
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < in_idle_pct) gap++;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {7'b0, ok, rw, cw};
    do @(posedge clk); while (!in_tready);
    if (adapter_step(mode, cw, rw, ok, r)) pending_results.push_back(r);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_noise();
    send_word(3'($urandom_range(7)), 12'($urandom), rand_mem_word(), 1'($urandom));
  endtask

  // sender stalls until every expected word is back, then lets the input
  // register empty out
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_HIGH_BITS) set_hbs = value[0];
    else if (idx == CFG_SETTLE) set_ticks = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // receiver backpressure, redrawn every cycle
  always @(negedge clk) out_tready <= ($urandom_range(99) >= out_idle_pct);

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch on %0s: got %0h, expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_result
    cxm_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word, kind", out_tuser, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser != want.kind) report_mismatch("kind", out_tuser, want.kind);
        if (out_tdata[1:0] != want.func_status)
          report_mismatch("func_status", out_tdata[1:0], want.func_status);
        if (out_tdata[13:2] != want.out_word)
          report_mismatch("out_word", out_tdata[13:2], want.out_word);
        if (out_tdata[14] != want.disconnect_after)
          report_mismatch("disconnect_after", out_tdata[14], want.disconnect_after);
        if (out_tdata[15] != want.deactivate)
          report_mismatch("deactivate", out_tdata[15], want.deactivate);
        if (out_tdata[39:16] != want.mem_address)
          report_mismatch("mem_address", out_tdata[39:16], want.mem_address);
        if (out_tdata[99:40] != want.mem_data)
          report_mismatch("mem_data", out_tdata[99:40], want.mem_data);
        if (out_tdata[OutDataW-1:100] != '0)
          report_mismatch("tdata padding", out_tdata[OutDataW-1:100], '0);
      end
    end
  end

  // no handshake of any kind for too long: the adapter is stuck
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset configuration: edge codes, a top-address write with wrap,
  // padding on disconnect, refused write, flag access by address bit 23
  task automatic test_directed();
    logic [ChanW-1:0] pattern;
    send_word(MODE_REPLY, 12'hFFF, {MemW{1'b1}}, 1'b1);   // nothing pending: ignored
    send_word(MODE_SPARE_A, 12'h5A5, {MemW{1'b1}}, 1'b0);
    send_word(MODE_SPARE_B, 12'hFFF, {MemW{1'b1}}, 1'b1);
    send_word(MODE_FUNC, FC_SELECT, '0, 1'b0);
    send_word(MODE_FUNC, FC_UNKNOWN, '0, 1'b0);
    send_word(MODE_FUNC, FC_STATUS | FC_DONT_CARE, '0, 1'b0);
    send_word(MODE_POLL, 12'h000, '0, 1'b0);
    send_word(MODE_FUNC, FC_WRITE, '0, 1'b0);
    send_word(MODE_WORD, 12'hFFF, '0, 1'b0);
    send_word(MODE_WORD, 12'hFFF, '0, 1'b0);
    for (int i = 0; i < 5; i++) begin
      pattern = (i % 2 == 0) ? 12'hFFF : 12'h000;
      send_word(MODE_WORD, pattern, '0, 1'b0);
    end
    send_word(MODE_REPLY, 12'h000, '0, 1'b1);             // address wraps to zero
    send_word(MODE_WORD, 12'hABC, '0, 1'b0);
    send_word(MODE_DISC, 12'h000, '0, 1'b0);              // one word, four zero words
    send_word(MODE_REPLY, 12'h000, '0, 1'b0);             // refused
    send_word(MODE_WORD, 12'h555, '0, 1'b0);              // ignored after abort
    send_word(MODE_FUNC, FC_RDONE, '0, 1'b0);
    send_word(MODE_WORD, 12'hC00, '0, 1'b0);
    send_word(MODE_WORD, 12'h007, '0, 1'b0);              // bit 23 set: flag access
    send_word(MODE_REPLY, 12'h000, '0, 1'b1);
    send_word(MODE_FUNC, FC_CLEAR, '0, 1'b0);
  endtask

  // settle counter must stick at its maximum instead of wrapping
  task automatic test_settle_saturation();
    drain_results();
    write_reg(CFG_HIGH_BITS, 8'd0);
    write_reg(CFG_SETTLE, SettleMax);
    send_word(MODE_FUNC, FC_READ, '0, 1'b0);
    send_word(MODE_WORD, 12'($urandom), '0, 1'b0);
    send_word(MODE_WORD, 12'($urandom), '0, 1'b0);
    for (int i = 0; i < 300; i++) begin
      if (i % 60 == 59) send_word(MODE_POLL, 12'h000, '0, 1'b0);   // never answered
      send_word(MODE_TICK, 12'($urandom), '0, 1'b0);
    end
    drain_results();
    write_reg(CFG_SETTLE, SettleMax - 8'd1);
    send_word(MODE_POLL, 12'h000, '0, 1'b0);
    send_word(MODE_REPLY, 12'h000, rand_mem_word(), 1'b1);
    repeat (4) send_word(MODE_POLL, 12'h000, '0, 1'b0);
  endtask

  // one randomly chosen operation, mostly well formed
  task automatic run_transaction();
    int pick;
    int steps;
    logic [ChanW-1:0] code;
    logic [ChanW-1:0] addr_hi;
    logic [ChanW-1:0] addr_lo;
    pick = $urandom_range(99);
    addr_hi = 12'($urandom);
    addr_lo = 12'($urandom);
    if ($urandom_range(9) == 0) begin
      addr_hi = 12'hFFF;
      addr_lo = 12'hFFE + 12'($urandom_range(1));
    end
    if (pick < 35) begin
      case ($urandom_range(3))
        0: code = FC_READ;
        1: code = FC_MREAD;
        2: code = FC_RDONE;
        default: code = FC_FLAG;
      endcase
      send_word(MODE_FUNC, code | (FC_DONT_CARE & 12'($urandom)), '0, 1'b0);
      send_word(MODE_WORD, addr_hi, '0, 1'b0);
      send_word(MODE_WORD, addr_lo, '0, 1'b0);
      steps = int'(set_ticks) + $urandom_range(4, 16);
      repeat (steps) begin
        if (st_aw != AW_NONE && $urandom_range(9) != 0)
          send_word(MODE_REPLY, 12'($urandom), rand_mem_word(), $urandom_range(9) != 0);
        else if (st_settle <= set_ticks && $urandom_range(9) != 0)
          send_word(MODE_TICK, 12'($urandom), '0, 1'b0);
        else if ($urandom_range(9) < 8)
          send_word(MODE_POLL, 12'($urandom), '0, 1'b0);
        else
          send_noise();
      end
    end else if (pick < 65) begin
      code = ($urandom_range(4) == 0) ? FC_MWRITE : FC_WRITE;
      send_word(MODE_FUNC, code | (FC_DONT_CARE & 12'($urandom)), '0, 1'b0);
      send_word(MODE_WORD, addr_hi, '0, 1'b0);
      send_word(MODE_WORD, addr_lo, '0, 1'b0);
      steps = $urandom_range(1, 14);
      repeat (steps) begin
        if (st_aw != AW_NONE && $urandom_range(9) != 0)
          send_word(MODE_REPLY, 12'($urandom), rand_mem_word(), $urandom_range(6) != 0);
        else if ($urandom_range(19) == 0)
          send_noise();
        else
          send_word(MODE_WORD, 12'($urandom), '0, 1'b0);
      end
      if ($urandom_range(2) == 0) send_word(MODE_DISC, 12'($urandom), '0, 1'b0);
      if (st_aw != AW_NONE && $urandom_range(4) != 0)
        send_word(MODE_REPLY, 12'($urandom), rand_mem_word(), $urandom_range(6) != 0);
    end else if (pick < 75) begin
      send_word(MODE_FUNC, FC_STATUS | (FC_DONT_CARE & 12'($urandom)), '0, 1'b0);
      if ($urandom_range(1) == 0) send_word(MODE_TICK, 12'($urandom), '0, 1'b0);
      send_word(MODE_POLL, 12'($urandom), '0, 1'b0);
    end else if (pick < 82) begin
      case ($urandom_range(2))
        0: code = FC_CLEAR;
        1: code = FC_SELECT;
        default: code = 12'($urandom);
      endcase
      send_word(MODE_FUNC, code, '0, 1'b0);
    end else begin
      repeat ($urandom_range(1, 3)) send_noise();
    end
  endtask

  task automatic test_random_traffic(input int count, input int in_pct, input int out_pct,
                                     input logic hbs, input logic [SettleW-1:0] ticks);
    int target;
    drain_results();
    in_idle_pct = in_pct;
    out_idle_pct = out_pct;
    write_reg(CFG_HIGH_BITS, {7'b0, hbs});
    write_reg(CFG_SETTLE, ticks);
    target = words_sent + count;
    while (words_sent < target) begin
      run_transaction();
      if ($urandom_range(99) == 0) drain_results();   // hold off until all is back
    end
  endtask

  initial begin
    st_op = OP_NONE;
    st_addr = '0;
    st_acnt = '0;
    st_bidx = '0;
    st_fetch = 1'b0;
    st_word = '0;
    st_status = ST_ACCEPT;
    st_settle = '0;
    st_aw = AW_NONE;
    st_wab = 1'b0;
    set_hbs = DefHighBitsSpecial;
    set_ticks = DefReadSettleTicks;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    in_idle_pct = 27;
    out_idle_pct = 71;
    test_directed();
    test_settle_saturation();
    test_random_traffic(440, 27, 71, 1'b1, 8'd0);
    test_random_traffic(440, 71, 27, 1'b0, 8'($urandom_range(1, 3)));
    test_random_traffic(440, 0, 0, 1'($urandom), 8'($urandom_range(4, 10)));

    drain_results();
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

/* channel_to_extended_memory_adapter.f */
rtl/cxm_pkg.sv
rtl/cxm_step.sv
rtl/channel_to_extended_memory_adapter.sv
rtl/cxm_checker.sv
tb/testbench.sv
